// ===== rtl/fit_policy_block_allocator_assert.svh =====
// assertion macros shared by the allocator checker
// no dependencies; expects aclk and aresetn in the including scope
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FPBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fpba_pkg.sv =====
// types, codes and sizes for the fit-policy block allocator
// used by fpba_cell and fit_policy_block_allocator
package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 32;
    localparam int IDX_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int BIDX_W     = 4;
    localparam int CHOSEN_W   = 4;
    localparam int BCNT_W     = 5;
    localparam int MODE_W     = 2;
    localparam int FUNC_W     = 2;
    localparam int CMP_W      = (IDX_W > BCNT_W) ? IDX_W : BCNT_W;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_FIT_MODE    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 1'd1;

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [SIZE_BITS-1:0] size_t;

    // search token walking down the cell chain
    typedef struct packed {
        logic              active;
        size_t             req_size;
        logic [MODE_W-1:0] mode;
        logic [BCNT_W-1:0] limit;
        logic              found;
        idx_t              pick_idx;
        size_t             pick_size;
    } token_t;

    // commands sent to every cell at once
    typedef struct packed {
        logic  load_en;
        idx_t  load_idx;
        size_t load_size;
        logic  clear_all;
        logic  take_en;
        idx_t  take_idx;
    } bcast_t;

endpackage

// ===== rtl/fpba_cell.sv =====
// one table entry of the allocator chain: block size, free mark, token stage
// depends on fpba_pkg
module fpba_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  fpba_pkg::idx_t   cell_idx,
    input  fpba_pkg::bcast_t bcast,
    input  fpba_pkg::token_t tok_in,
    output fpba_pkg::token_t tok_out
);
    import fpba_pkg::*;

    size_t  size_reg, size_next;
    logic   free_reg, free_next;
    token_t tok_reg, tok_next;
    logic   in_range, hit, better;

    always_comb begin
        in_range = CMP_W'(cell_idx) < CMP_W'(tok_in.limit);
        hit = tok_in.active && free_reg && in_range && (size_reg >= tok_in.req_size);
        case (tok_in.mode)
            MODE_BEST:  better = !tok_in.found || (size_reg < tok_in.pick_size);
            MODE_WORST: better = !tok_in.found || (size_reg > tok_in.pick_size);
            default:    better = !tok_in.found;
        endcase
        tok_next = tok_in;
        if (hit && better) begin
            tok_next.found     = 1'b1;
            tok_next.pick_idx  = cell_idx;
            tok_next.pick_size = size_reg;
        end
    end

    always_comb begin
        size_next = size_reg;
        free_next = free_reg;
        if (bcast.load_en && bcast.load_idx == cell_idx) begin
            size_next = bcast.load_size;
        end
        if (bcast.clear_all) begin
            free_next = 1'b1;
        end else if (bcast.load_en && bcast.load_idx == cell_idx) begin
            free_next = 1'b1;
        end else if (bcast.take_en && bcast.take_idx == cell_idx) begin
            free_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            free_reg <= free_next;
            tok_reg  <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        size_reg <= size_next;
    end

    assign tok_out = tok_reg;

endmodule

// ===== rtl/fit_policy_block_allocator.sv =====
// top level of the fit-policy block allocator: control, config and the cell chain
// depends on fpba_pkg and fpba_cell
//
// Each of the NUM_BLOCKS table entries lives in its own cell; an allocate beat
// sends a search token down the chain, one cell per cycle, and each cell folds
// its block into the running first/best/worst-fit choice. An allocate waits in
// ST_SCAN until the token leaves the last cell, as set by the length of the chain;
// load, clear and unused function codes skip it. All wait in ST_DONE for a free
// output register. One item is worked on at a time; a finished result waits in the output
// register while the next beat is accepted. No clearing pass follows reset.
module fit_policy_block_allocator (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_we,
    input  logic [fpba_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [39:0]                      s_tdata,  // block_index[3:0], size_value[35:4]
    input  logic [1:0]                       s_tuser,  // func[1:0]
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // chosen_index[3:0]
    output logic                             m_tuser   // granted
);
    import fpba_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t              state_reg, state_next;
    logic                pend_grant_reg, pend_grant_next;
    idx_t                pend_idx_reg, pend_idx_next;
    logic                pend_take_reg, pend_take_next;
    logic                m_valid_reg, m_valid_next;
    logic                m_grant_reg, m_grant_next;
    logic [CHOSEN_W-1:0] m_idx_reg, m_idx_next;
    logic [MODE_W-1:0]   fit_mode_reg;
    logic [BCNT_W-1:0]   block_count_reg;

    logic                accept, out_free, load_ok;
    logic [FUNC_W-1:0]   in_func;
    logic [BIDX_W-1:0]   in_bidx;
    size_t               in_size;
    bcast_t              bcast;
    token_t              tok_chain [0:NUM_BLOCKS];

    assign in_func  = s_tuser;
    assign in_bidx  = s_tdata[BIDX_W-1:0];
    assign in_size  = s_tdata[BIDX_W +: SIZE_BITS];
    assign s_tready = aresetn && (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign load_ok  = 32'(in_bidx) < NUM_BLOCKS;

    always_comb begin
        tok_chain[0]           = '0;
        tok_chain[0].active    = accept && (in_func == FUNC_ALLOC);
        tok_chain[0].req_size  = in_size;
        tok_chain[0].mode      = fit_mode_reg;
        tok_chain[0].limit     = block_count_reg;

        bcast.load_en   = accept && (in_func == FUNC_LOAD) && load_ok;
        bcast.load_idx  = IDX_W'(in_bidx);
        bcast.load_size = in_size;
        bcast.clear_all = accept && (in_func == FUNC_CLEAR);
        bcast.take_en   = (state_reg == ST_DONE) && out_free && pend_take_reg;
        bcast.take_idx  = pend_idx_reg;
    end

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        fpba_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .cell_idx (IDX_W'(g)),
            .bcast    (bcast),
            .tok_in   (tok_chain[g]),
            .tok_out  (tok_chain[g+1])
        );
    end

    always_comb begin
        state_next      = state_reg;
        pend_grant_next = pend_grant_reg;
        pend_idx_next   = pend_idx_reg;
        pend_take_next  = pend_take_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_grant_next    = m_grant_reg;
        m_idx_next      = m_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    pend_grant_next = 1'b0;
                    pend_idx_next   = '0;
                    pend_take_next  = 1'b0;
                    state_next      = ST_DONE;
                    case (in_func)
                        FUNC_LOAD: begin
                            if (load_ok) begin
                                pend_grant_next = 1'b1;
                                pend_idx_next   = IDX_W'(in_bidx);
                            end
                        end
                        FUNC_ALLOC: state_next = ST_SCAN;
                        FUNC_CLEAR: pend_grant_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (tok_chain[NUM_BLOCKS].active) begin
                    pend_grant_next = tok_chain[NUM_BLOCKS].found;
                    pend_idx_next   = tok_chain[NUM_BLOCKS].found ?
                                      tok_chain[NUM_BLOCKS].pick_idx : '0;
                    pend_take_next  = tok_chain[NUM_BLOCKS].found;
                    state_next      = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_grant_next = pend_grant_reg;
                    m_idx_next   = CHOSEN_W'(pend_idx_reg);
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            pend_take_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
            fit_mode_reg    <= MODE_FIRST;
            block_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            pend_take_reg <= pend_take_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_FIT_MODE:    fit_mode_reg    <= cfg_wdata[MODE_W-1:0];
                    REG_BLOCK_COUNT: block_count_reg <= cfg_wdata[BCNT_W-1:0];
                    default: ;
                endcase
            end
        end
        pend_grant_reg <= pend_grant_next;
        pend_idx_reg   <= pend_idx_next;
        m_grant_reg    <= m_grant_next;
        m_idx_reg      <= m_idx_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_grant_reg;
    assign m_tdata  = {{(8-CHOSEN_W){1'b0}}, m_idx_reg};

endmodule

// ===== rtl/fpba_checker.sv =====
// port-level checks for the fit-policy block allocator, bound to the top level
// depends on fit_policy_block_allocator_assert.svh
`include "fit_policy_block_allocator_assert.svh"

module fpba_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tuser
);

    // stalled result beat keeps its payload
    `FPBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed while stalled")

    // a refused item reports index zero
    `FPBA_ASSERT_NOW(a_refused_zero, m_tvalid && !m_tuser,
        m_tdata == 8'd0, "refused result carries nonzero index")

    // one item in flight: no beat is taken right after another
    `FPBA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready,
        !s_tready, "input ready right after an accepted beat")

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);
